@@ hdl/tsrr_pkg.sv @@
package tsrr_pkg;

  localparam int DEF_SLOTS   = 16;
  localparam int DEF_ID_BITS = 16;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FID_W    = 16;
  localparam int RSLOT_W  = 4;
  localparam int PC_W     = 4;

  // command modes
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YIELD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_JOIN   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SWITCH = 2'd3;

  // slot states
  localparam logic [1:0] SS_FREE     = 2'd0;
  localparam logic [1:0] SS_RUNNABLE = 2'd1;
  localparam logic [1:0] SS_RUNNING  = 2'd2;
  localparam logic [1:0] SS_FINISHED = 2'd3;

  // scan sources
  localparam logic [1:0] SC_NONE  = 2'd0;
  localparam logic [1:0] SC_FREE  = 2'd1;
  localparam logic [1:0] SC_RUN   = 2'd2;
  localparam logic [1:0] SC_MATCH = 2'd3;

  // datapath actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_FINISH = 3'd2;
  localparam logic [2:0] ACT_SWITCH = 3'd3;
  localparam logic [2:0] ACT_FREE   = 3'd4;
  localparam logic [2:0] ACT_MISS   = 3'd5;

  // branch kinds
  localparam logic [1:0] BR_NEXT      = 2'd0;
  localparam logic [1:0] BR_JUMP      = 2'd1;
  localparam logic [1:0] BR_NOT_FOUND = 2'd2;
  localparam logic [1:0] BR_NOT_FIN   = 2'd3;

  // program steps
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_CR_SCAN  = 4'd1;
  localparam logic [PC_W-1:0] PC_CR_PICK  = 4'd2;
  localparam logic [PC_W-1:0] PC_CR_WRITE = 4'd3;
  localparam logic [PC_W-1:0] PC_YD_SCAN  = 4'd4;
  localparam logic [PC_W-1:0] PC_YD_PICK  = 4'd5;
  localparam logic [PC_W-1:0] PC_YD_SWAP  = 4'd6;
  localparam logic [PC_W-1:0] PC_EX_MARK  = 4'd7;
  localparam logic [PC_W-1:0] PC_JN_SCAN  = 4'd8;
  localparam logic [PC_W-1:0] PC_JN_PICK  = 4'd9;
  localparam logic [PC_W-1:0] PC_JN_TEST  = 4'd10;
  localparam logic [PC_W-1:0] PC_JN_FIN   = 4'd11;
  localparam logic [PC_W-1:0] PC_JN_FREE  = 4'd12;
  localparam logic [PC_W-1:0] PC_JN_MISS  = 4'd13;

  typedef struct packed {
    logic [1:0]      scan;
    logic            pick;
    logic            rr;
    logic [2:0]      act;
    logic [1:0]      br;
    logic            done;
    logic [PC_W-1:0] target;
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t cw;
    cw = '{scan: SC_NONE, pick: 1'b0, rr: 1'b0, act: ACT_NONE, br: BR_NEXT,
           done: 1'b0, target: PC_IDLE};
    case (pc)
      PC_CR_SCAN:  cw.scan = SC_FREE;
      PC_CR_PICK:  cw.pick = 1'b1;
      PC_CR_WRITE: begin
        cw.act  = ACT_CREATE;
        cw.done = 1'b1;
      end
      PC_YD_SCAN:  cw.scan = SC_RUN;
      PC_YD_PICK: begin
        cw.pick = 1'b1;
        cw.rr   = 1'b1;
      end
      PC_YD_SWAP: begin
        cw.act  = ACT_SWITCH;
        cw.done = 1'b1;
      end
      PC_EX_MARK: begin
        cw.act    = ACT_FINISH;
        cw.br     = BR_JUMP;
        cw.target = PC_YD_SCAN;
      end
      PC_JN_SCAN:  cw.scan = SC_MATCH;
      PC_JN_PICK:  cw.pick = 1'b1;
      PC_JN_TEST: begin
        cw.br     = BR_NOT_FOUND;
        cw.target = PC_JN_MISS;
      end
      PC_JN_FIN: begin
        cw.br     = BR_NOT_FIN;
        cw.target = PC_YD_SCAN;
      end
      PC_JN_FREE: begin
        cw.act  = ACT_FREE;
        cw.done = 1'b1;
      end
      PC_JN_MISS: begin
        cw.act  = ACT_MISS;
        cw.done = 1'b1;
      end
      default: cw.target = PC_IDLE;
    endcase
    return cw;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [MODE_W-1:0] mode);
    logic [PC_W-1:0] pc;
    case (mode)
      MODE_CREATE: pc = PC_CR_SCAN;
      MODE_YIELD:  pc = PC_YD_SCAN;
      MODE_EXIT:   pc = PC_EX_MARK;
      MODE_JOIN:   pc = PC_JN_SCAN;
      default:     pc = PC_YD_SCAN;
    endcase
    return pc;
  endfunction

endpackage

@@ hdl/thread_slot_round_robin_scheduler_top.sv @@
// Round-robin thread slot scheduler. One command is taken at a time and gives exactly one
// result. A small program in a read-only table steps a datapath that scans the slot table
// into a flag vector, picks a slot with a priority (or round-robin) search, then updates
// the table. Create and yield take 3 steps, exit 4, join 4 (not found), 5 (freeing a
// finished thread) or 7 (join of an unfinished thread, which yields), plus the idle step
// that dispatches; the step count of the program sets the rate. The result sits in an output
// register, and the last step of a command waits only if an earlier result is still
// untaken. The table is ready right after reset with no clearing pass.
module thread_slot_round_robin_scheduler_top #(
  parameter int SLOTS   = tsrr_pkg::DEF_SLOTS,
  parameter int ID_BITS = tsrr_pkg::DEF_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsrr_pkg::MODE_W-1:0]   mode,
  input  logic [tsrr_pkg::FID_W-1:0]    join_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsrr_pkg::STATUS_W-1:0] status,
  output logic [tsrr_pkg::FID_W-1:0]    new_id,
  output logic                          switched,
  output logic [tsrr_pkg::RSLOT_W-1:0]  running_slot
);

  localparam int CUR_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [1:0]         slot_status [SLOTS];
  logic [ID_BITS-1:0] slot_id     [SLOTS];
  logic [CUR_BITS-1:0] cur;
  logic [ID_BITS-1:0] next_id;
  logic [ID_BITS-1:0] jid;
  logic               jflag;
  logic [tsrr_pkg::PC_W-1:0] pc;
  logic [tsrr_pkg::PC_W-1:0] pc_next;
  logic [SLOTS-1:0]   vec;
  logic [SLOTS-1:0]   sel_oh;
  logic               found;

  tsrr_pkg::ctl_t cw;
  logic [SLOTS-1:0]    free_v, run_v, fin_v, match_v, hi_mask, cur_oh;
  logic [SLOTS-1:0]    low_oh, hi_oh, hi_v, pick_oh;
  logic [CUR_BITS-1:0] sel_idx;
  logic [CUR_BITS-1:0] cur_after;
  logic [CUR_BITS+tsrr_pkg::RSLOT_W-1:0] cur_ext;
  logic [ID_BITS+tsrr_pkg::FID_W-1:0]    jid_ext;
  logic [ID_BITS+tsrr_pkg::FID_W-1:0]    nid_ext;
  logic [ID_BITS-1:0]  id_inc;
  logic                fin_hit;
  logic                go;

  assign cw       = tsrr_pkg::ucode(pc);
  assign in_ready = (pc == tsrr_pkg::PC_IDLE);
  // last step holds while an earlier result is untaken
  assign go       = !(cw.done && out_valid && !out_ready);
  assign jid_ext  = {{ID_BITS{1'b0}}, join_id};
  assign nid_ext  = {{tsrr_pkg::FID_W{1'b0}}, next_id};
  assign id_inc   = (next_id == {ID_BITS{1'b1}}) ? ID_BITS'(1) : next_id + ID_BITS'(1);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_v[i]  = (slot_status[i] == tsrr_pkg::SS_FREE) && (i != 0);
      run_v[i]   = (slot_status[i] == tsrr_pkg::SS_RUNNABLE);
      fin_v[i]   = (slot_status[i] == tsrr_pkg::SS_FINISHED);
      match_v[i] = (slot_status[i] != tsrr_pkg::SS_FREE) &&
                   (slot_id[i] == jid);
      hi_mask[i] = (i > int'(cur));
      cur_oh[i]  = (int'(cur) == i);
    end
  end

  // lowest set bit, and round-robin search after the current slot
  always_comb begin
    low_oh  = vec & (~vec + SLOTS'(1));
    hi_v    = vec & hi_mask;
    hi_oh   = hi_v & (~hi_v + SLOTS'(1));
    pick_oh = (cw.rr && (|hi_v)) ? hi_oh : low_oh;
  end

  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_oh[i]) sel_idx = sel_idx | CUR_BITS'(i);
    end
  end

  assign fin_hit   = |(sel_oh & fin_v);
  assign cur_after = (cw.act == tsrr_pkg::ACT_SWITCH && found) ? sel_idx : cur;
  assign cur_ext   = {{tsrr_pkg::RSLOT_W{1'b0}}, cur_after};

  always_comb begin
    case (cw.br)
      tsrr_pkg::BR_NEXT:      pc_next = pc + tsrr_pkg::PC_W'(1);
      tsrr_pkg::BR_JUMP:      pc_next = cw.target;
      tsrr_pkg::BR_NOT_FOUND: pc_next = found ? pc + tsrr_pkg::PC_W'(1) : cw.target;
      tsrr_pkg::BR_NOT_FIN:   pc_next = fin_hit ? pc + tsrr_pkg::PC_W'(1) : cw.target;
      default:                pc_next = tsrr_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_status[i] <= (i == 0) ? tsrr_pkg::SS_RUNNING : tsrr_pkg::SS_FREE;
        slot_id[i]     <= (i == 0) ? ID_BITS'(1) : '0;
      end
      cur       <= '0;
      next_id   <= ID_BITS'(2);
      pc        <= tsrr_pkg::PC_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
      jflag     <= 1'b0;
    end else begin
      if (go && cw.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pc == tsrr_pkg::PC_IDLE) begin
        if (in_valid) begin
          pc    <= tsrr_pkg::entry(mode);
          jflag <= (mode == tsrr_pkg::MODE_JOIN);
          jid   <= jid_ext[ID_BITS-1:0];
        end
      end else if (go) begin
        case (cw.scan)
          tsrr_pkg::SC_FREE:  vec <= free_v;
          tsrr_pkg::SC_RUN:   vec <= run_v;
          tsrr_pkg::SC_MATCH: vec <= match_v;
          default:            vec <= vec;
        endcase
        if (cw.pick) begin
          sel_oh <= pick_oh;
          found  <= |vec;
        end

        case (cw.act)
          tsrr_pkg::ACT_CREATE: begin
            if (found) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (sel_oh[i]) begin
                  slot_status[i] <= tsrr_pkg::SS_RUNNABLE;
                  slot_id[i]     <= next_id;
                end
              end
              next_id <= id_inc;
            end
            status   <= found ? tsrr_pkg::ST_OK : tsrr_pkg::ST_FULL;
            new_id   <= found ? nid_ext[tsrr_pkg::FID_W-1:0] : '0;
            switched <= 1'b0;
          end
          tsrr_pkg::ACT_FINISH: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (cur_oh[i]) slot_status[i] <= tsrr_pkg::SS_FINISHED;
            end
          end
          tsrr_pkg::ACT_SWITCH: begin
            if (found) begin
              // old runner steps back; the picked slot wins if it is the same one
              for (int i = 0; i < SLOTS; i++) begin
                if (sel_oh[i]) begin
                  slot_status[i] <= tsrr_pkg::SS_RUNNING;
                end else if (cur_oh[i] && slot_status[i] == tsrr_pkg::SS_RUNNING) begin
                  slot_status[i] <= tsrr_pkg::SS_RUNNABLE;
                end
              end
              cur <= sel_idx;
            end
            status   <= (jflag || !found) ? tsrr_pkg::ST_NO_SWITCH : tsrr_pkg::ST_OK;
            new_id   <= '0;
            switched <= found;
          end
          tsrr_pkg::ACT_FREE: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (sel_oh[i]) begin
                slot_status[i] <= tsrr_pkg::SS_FREE;
                slot_id[i]     <= '0;
              end
            end
            status   <= tsrr_pkg::ST_OK;
            new_id   <= '0;
            switched <= 1'b0;
          end
          tsrr_pkg::ACT_MISS: begin
            status   <= tsrr_pkg::ST_NOT_FOUND;
            new_id   <= '0;
            switched <= 1'b0;
          end
          default: begin
          end
        endcase

        if (cw.done) begin
          running_slot <= cur_ext[tsrr_pkg::RSLOT_W-1:0];
          pc           <= tsrr_pkg::PC_IDLE;
        end else begin
          pc <= pc_next;
        end
      end
    end
  end

endmodule

@@ hdl/tsrr_checker.sv @@
module tsrr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tsrr_pkg::STATUS_W-1:0] status,
  input logic [tsrr_pkg::FID_W-1:0]    new_id,
  input logic                          switched,
  input logic [tsrr_pkg::RSLOT_W-1:0]  running_slot
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(new_id)
      && $stable(switched) && $stable(running_slot))
    else $error("result changed while stalled");

  // one command in flight: a transfer in closes the input side
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // only a successful create reports an id
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_id != '0 |-> status == tsrr_pkg::ST_OK && !switched)
    else $error("id reported outside a successful create");

  // full table and unknown id never switch
  a_no_sw: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tsrr_pkg::ST_FULL || status == tsrr_pkg::ST_NOT_FOUND)
      |-> !switched && new_id == '0)
    else $error("switch or id reported with a failing status");

endmodule

bind thread_slot_round_robin_scheduler_top tsrr_checker u_tsrr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .new_id       (new_id),
  .switched     (switched),
  .running_slot (running_slot)
);
